/* design/lpl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpl_pkg
// Shared types and constants of the low-power-listening MAC sender.
// ----------------------------------------------------------------------------
package lpl_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [15:0] BROADCAST_ADDRESS = 16'hFFFF;

    localparam logic [2:0] FUNC_TICK = 3'd0;
    localparam logic [2:0] FUNC_ENQ = 3'd1;
    localparam logic [2:0] FUNC_ACK = 3'd2;
    localparam logic [2:0] FUNC_OK = 3'd3;
    localparam logic [2:0] FUNC_STOP = 3'd4;
    localparam logic [2:0] FUNC_PWR = 3'd5;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_START_TRAIN = 3'd1;
    localparam logic [2:0] PH_START_MSG = 3'd2;
    localparam logic [2:0] PH_BACKOFF_INIT = 3'd3;
    localparam logic [2:0] PH_BACKOFF_CONG = 3'd4;
    localparam logic [2:0] PH_BACKOFF_DONE = 3'd5;
    localparam logic [2:0] PH_TRANSMITTING = 3'd6;
    localparam logic [2:0] PH_WAIT_RX = 3'd7;

    localparam logic [2:0] EV_RX = 3'd0;
    localparam logic [2:0] EV_BUSY = 3'd1;
    localparam logic [2:0] EV_TX = 3'd2;
    localparam logic [2:0] EV_FAIL = 3'd3;
    localparam logic [2:0] EV_FINISHED = 3'd4;
    localparam logic [2:0] EV_DROP = 3'd5;

    localparam logic [2:0] CFG_TRAIN = 3'd0;
    localparam logic [2:0] CFG_IB_MIN = 3'd1;
    localparam logic [2:0] CFG_IB_SPAN = 3'd2;
    localparam logic [2:0] CFG_CB_MIN = 3'd3;
    localparam logic [2:0] CFG_CB_SPAN = 3'd4;
    localparam logic [2:0] CFG_ACK_WAIT = 3'd5;
    localparam logic [2:0] CFG_BC_GAP = 3'd6;
    localparam logic [2:0] CFG_SETTLE = 3'd7;

    localparam logic [1:0] CH_CLEAR = 2'd0;
    localparam logic [1:0] CH_BUSY = 2'd1;

    typedef struct packed {
        logic [2:0]  ev;
        logic [15:0] tag;
        logic [15:0] dest;
    } res_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] tag;
        logic [15:0] dest;
        logic [1:0]  chan;
        logic [15:0] rnd;
    } item_t;

endpackage

/* design/lpl_mac_sender.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpl_mac_sender
// Low-power-listening MAC sender: event driven packet queue and train control.
// ----------------------------------------------------------------------------
// Each accepted item is registered, then processed in one pass that updates
// the queue, timers and phase and loads up to four result items into an
// output buffer. A new item is taken whenever the buffer is empty or its last
// result is being taken, so an item causing one result flows at one per
// cycle while m_ready is high; an item causing several results holds the
// input while the buffer drains; one causing none leaves it empty. The
// random span product is registered in the input stage (16x16 multiply each).
module lpl_mac_sender (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [15:0] s_packet_tag,
    input  logic [15:0] s_destination,
    input  logic [1:0]  s_channel_status,
    input  logic [15:0] s_random_fraction,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [15:0] m_out_tag,
    output logic [15:0] m_out_destination,
    output logic        m_last
);

    logic [31:0] train_reg;
    logic [15:0] ibmin_reg, ibspan_reg, cbmin_reg, cbspan_reg;
    logic [15:0] ackw_reg, bcgap_reg, settle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            train_reg  <= 32'd10000;
            ibmin_reg  <= 16'd10;
            ibspan_reg <= 16'd20;
            cbmin_reg  <= 16'd10;
            cbspan_reg <= 16'd20;
            ackw_reg   <= 16'd5;
            bcgap_reg  <= 16'd2;
            settle_reg <= 16'd2;
        end else if (cfg_we) begin
            case (cfg_index)
                lpl_pkg::CFG_TRAIN:    train_reg  <= cfg_data;
                lpl_pkg::CFG_IB_MIN:   ibmin_reg  <= cfg_data[15:0];
                lpl_pkg::CFG_IB_SPAN:  ibspan_reg <= cfg_data[15:0];
                lpl_pkg::CFG_CB_MIN:   cbmin_reg  <= cfg_data[15:0];
                lpl_pkg::CFG_CB_SPAN:  cbspan_reg <= cfg_data[15:0];
                lpl_pkg::CFG_ACK_WAIT: ackw_reg   <= cfg_data[15:0];
                lpl_pkg::CFG_BC_GAP:   bcgap_reg  <= cfg_data[15:0];
                lpl_pkg::CFG_SETTLE:   settle_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // input stage
    logic           in_v_reg;
    lpl_pkg::item_t in_reg;
    logic [15:0]    ib_off_reg, cb_off_reg;
    logic           take_in;

    // output buffer
    lpl_pkg::res_t  ob_reg [4];
    logic [2:0]     ob_n_reg;
    logic [1:0]     ob_rd_reg;
    logic           ob_empty_next_ok;
    logic           proc;

    assign ob_empty_next_ok = (ob_n_reg == 3'd0) ||
        (m_ready && ({1'b0, ob_rd_reg} + 3'd1 == ob_n_reg));
    assign proc = in_v_reg && ob_empty_next_ok;
    assign s_ready = !in_v_reg || proc;
    assign take_in = s_valid && s_ready;

    logic [31:0] ib_prod, cb_prod;
    assign ib_prod = 32'(s_random_fraction) * 32'(ibspan_reg);
    assign cb_prod = 32'(s_random_fraction) * 32'(cbspan_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_ready) begin
            in_v_reg <= s_valid;
        end
        if (take_in) begin
            in_reg     <= '{s_func, s_packet_tag, s_destination, s_channel_status,
                            s_random_fraction};
            ib_off_reg <= ib_prod[31:16];
            cb_off_reg <= cb_prod[31:16];
        end
    end

    // state
    logic [2:0]  phase_reg, phase_next;
    logic        perm_reg, perm_next;
    logic        lapsed_reg, lapsed_next;
    logic [lpl_pkg::QPTR_W-1:0] head_reg, head_next;
    logic [lpl_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    logic [32:0] win_reg, win_next;
    logic [16:0] gap_reg, gap_next;
    logic [16:0] bo_reg, bo_next;
    logic [31:0] qmem [lpl_pkg::QUEUE_DEPTH];

    lpl_pkg::res_t res [4];
    logic [2:0]    nres;
    logic          qwe;
    logic [lpl_pkg::QPTR_W-1:0] qwa;
    logic [31:0]   hent;

    function automatic logic [16:0] at_least_one(input logic [16:0] d);
        return (d == 17'd0) ? 17'd1 : d;
    endfunction

    function automatic logic [lpl_pkg::QPTR_W-1:0] wrap_add(
        input logic [lpl_pkg::QPTR_W-1:0] a, input logic [lpl_pkg::QCNT_W-1:0] b);
        logic [lpl_pkg::QCNT_W:0] s;
        s = (lpl_pkg::QCNT_W + 1)'(a) + (lpl_pkg::QCNT_W + 1)'(b);
        if (s >= (lpl_pkg::QCNT_W + 1)'(lpl_pkg::QUEUE_DEPTH))
            s = s - (lpl_pkg::QCNT_W + 1)'(lpl_pkg::QUEUE_DEPTH);
        return s[lpl_pkg::QPTR_W-1:0];
    endfunction

    // the flattened control: steps are bounded (at most one train started)
    always_comb begin
        logic gap_fire, back_fire, run;
        logic [15:0] dest;
        phase_next  = phase_reg;
        perm_next   = perm_reg;
        lapsed_next = lapsed_reg;
        head_next   = head_reg;
        cnt_next    = cnt_reg;
        win_next    = win_reg;
        gap_next    = gap_reg;
        bo_next     = bo_reg;
        qwe         = 1'b0;
        qwa         = wrap_add(head_reg, cnt_reg);
        nres        = 3'd0;
        for (int i = 0; i < 4; i++) res[i] = '{lpl_pkg::EV_RX, 16'd0, 16'd0};
        gap_fire  = 1'b0;
        back_fire = 1'b0;
        run       = 1'b0;
        hent      = qmem[head_reg];
        dest      = hent[15:0];
        case (in_reg.func)
            lpl_pkg::FUNC_TICK: begin
                if (win_reg != 33'd0) begin
                    win_next = win_reg - 33'd1;
                    if (win_next == 33'd0) lapsed_next = 1'b1;
                end
                if (gap_reg != 17'd0) begin
                    gap_next = gap_reg - 17'd1;
                    gap_fire = (gap_next == 17'd0);
                end
                if (bo_reg != 17'd0) begin
                    bo_next = bo_reg - 17'd1;
                    back_fire = (bo_next == 17'd0);
                end
                if (gap_fire) begin
                    // start of next copy, looping over at most two heads
                    phase_next = lpl_pkg::PH_START_MSG;
                    for (int it = 0; it < 3; it++) begin
                        if (phase_next == lpl_pkg::PH_START_MSG ||
                            phase_next == lpl_pkg::PH_START_TRAIN) begin
                            hent = qmem[head_next];
                            dest = hent[15:0];
                            if (cnt_next == '0 || !perm_next) begin
                                res[nres[1:0]] = '{lpl_pkg::EV_FINISHED, 16'd0, 16'd0};
                                nres = nres + 3'd1;
                                phase_next = lpl_pkg::PH_IDLE;
                            end else if (phase_next == lpl_pkg::PH_START_TRAIN) begin
                                lapsed_next = 1'b0;
                                win_next = (train_reg == 32'd0) ? 33'd1 : 33'(train_reg);
                                bo_next = at_least_one(17'(ibmin_reg) + 17'(ib_off_reg));
                                phase_next = lpl_pkg::PH_BACKOFF_INIT;
                            end else if (!lapsed_next) begin
                                bo_next = at_least_one(17'(ibmin_reg) + 17'(ib_off_reg));
                                phase_next = lpl_pkg::PH_BACKOFF_INIT;
                            end else begin
                                if (dest != lpl_pkg::BROADCAST_ADDRESS) begin
                                    res[nres[1:0]] = '{lpl_pkg::EV_FAIL, 16'd0, dest};
                                    nres = nres + 3'd1;
                                end
                                head_next = wrap_add(head_next, lpl_pkg::QCNT_W'(1));
                                cnt_next = cnt_next - lpl_pkg::QCNT_W'(1);
                                res[nres[1:0]] = '{lpl_pkg::EV_RX, 16'd0, 16'd0};
                                nres = nres + 3'd1;
                                if (cnt_next == '0) begin
                                    res[nres[1:0]] = '{lpl_pkg::EV_FINISHED, 16'd0, 16'd0};
                                    nres = nres + 3'd1;
                                    phase_next = lpl_pkg::PH_IDLE;
                                end else begin
                                    res[nres[1:0]] = '{lpl_pkg::EV_BUSY, 16'd0, 16'd0};
                                    nres = nres + 3'd1;
                                    phase_next = lpl_pkg::PH_START_TRAIN;
                                end
                            end
                        end
                    end
                end
                if (back_fire && bo_next == 17'd0) begin
                    hent = qmem[head_next];
                    dest = hent[15:0];
                    if (cnt_next == '0 || !perm_next) begin
                        res[nres[1:0]] = '{lpl_pkg::EV_FINISHED, 16'd0, 16'd0};
                        nres = nres + 3'd1;
                        phase_next = lpl_pkg::PH_IDLE;
                    end else if (in_reg.chan == lpl_pkg::CH_CLEAR) begin
                        res[nres[1:0]] = '{lpl_pkg::EV_TX, hent[31:16], dest};
                        nres = nres + 3'd1;
                        gap_next = at_least_one(17'((dest == lpl_pkg::BROADCAST_ADDRESS)
                                                     ? bcgap_reg : ackw_reg));
                        phase_next = lpl_pkg::PH_TRANSMITTING;
                    end else if (in_reg.chan == lpl_pkg::CH_BUSY) begin
                        bo_next = at_least_one(17'(cbmin_reg) + 17'(cb_off_reg));
                        phase_next = lpl_pkg::PH_BACKOFF_CONG;
                    end else begin
                        bo_next = at_least_one(17'(settle_reg));
                        phase_next = lpl_pkg::PH_WAIT_RX;
                    end
                end
            end
            lpl_pkg::FUNC_ENQ: begin
                if (32'(cnt_reg) >= 32'(lpl_pkg::QUEUE_DEPTH)) begin
                    res[0] = '{lpl_pkg::EV_DROP, in_reg.tag, in_reg.dest};
                    nres = 3'd1;
                end else begin
                    qwe = 1'b1;
                    cnt_next = cnt_reg + lpl_pkg::QCNT_W'(1);
                end
                run = perm_reg && phase_reg == lpl_pkg::PH_IDLE;
            end
            lpl_pkg::FUNC_ACK: begin
                if (phase_reg == lpl_pkg::PH_TRANSMITTING) begin
                    win_next = 33'd0;
                    gap_next = 17'd0;
                    if (cnt_reg != '0) begin
                        head_next = wrap_add(head_reg, lpl_pkg::QCNT_W'(1));
                        cnt_next = cnt_reg - lpl_pkg::QCNT_W'(1);
                    end
                    run = 1'b1;
                end
            end
            lpl_pkg::FUNC_OK: begin
                perm_next = 1'b1;
                run = 1'b1;
            end
            lpl_pkg::FUNC_STOP: begin
                perm_next = 1'b0;
                if (phase_reg != lpl_pkg::PH_TRANSMITTING) begin
                    win_next = 33'd0;
                    gap_next = 17'd0;
                    bo_next = 17'd0;
                    phase_next = lpl_pkg::PH_IDLE;
                end
            end
            lpl_pkg::FUNC_PWR: begin
                phase_next = lpl_pkg::PH_IDLE;
                perm_next = 1'b0;
                lapsed_next = 1'b0;
                head_next = '0;
                cnt_next = '0;
                win_next = 33'd0;
                gap_next = 17'd0;
                bo_next = 17'd0;
            end
            default: ;
        endcase
        if (run) begin
            res[nres[1:0]] = '{lpl_pkg::EV_RX, 16'd0, 16'd0};
            nres = nres + 3'd1;
            if (cnt_next == '0) begin
                res[nres[1:0]] = '{lpl_pkg::EV_FINISHED, 16'd0, 16'd0};
                nres = nres + 3'd1;
                phase_next = lpl_pkg::PH_IDLE;
            end else begin
                res[nres[1:0]] = '{lpl_pkg::EV_BUSY, 16'd0, 16'd0};
                nres = nres + 3'd1;
                if (!perm_next) begin
                    res[nres[1:0]] = '{lpl_pkg::EV_FINISHED, 16'd0, 16'd0};
                    nres = nres + 3'd1;
                    phase_next = lpl_pkg::PH_IDLE;
                end else begin
                    lapsed_next = 1'b0;
                    win_next = (train_reg == 32'd0) ? 33'd1 : 33'(train_reg);
                    bo_next = at_least_one(17'(ibmin_reg) + 17'(ib_off_reg));
                    phase_next = lpl_pkg::PH_BACKOFF_INIT;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= lpl_pkg::PH_IDLE;
            perm_reg   <= 1'b0;
            lapsed_reg <= 1'b0;
            head_reg   <= '0;
            cnt_reg    <= '0;
            win_reg    <= 33'd0;
            gap_reg    <= 17'd0;
            bo_reg     <= 17'd0;
            ob_n_reg   <= 3'd0;
            ob_rd_reg  <= 2'd0;
        end else begin
            if (proc) begin
                phase_reg  <= phase_next;
                perm_reg   <= perm_next;
                lapsed_reg <= lapsed_next;
                head_reg   <= head_next;
                cnt_reg    <= cnt_next;
                win_reg    <= win_next;
                gap_reg    <= gap_next;
                bo_reg     <= bo_next;
                ob_n_reg   <= nres;
                ob_rd_reg  <= 2'd0;
            end else if (m_valid && m_ready) begin
                if ({1'b0, ob_rd_reg} + 3'd1 == ob_n_reg) begin
                    ob_n_reg  <= 3'd0;
                    ob_rd_reg <= 2'd0;
                end else begin
                    ob_rd_reg <= ob_rd_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            for (int i = 0; i < 4; i++) ob_reg[i] <= res[i];
            if (qwe) qmem[qwa] <= {in_reg.tag, in_reg.dest};
        end
    end

    assign m_valid           = ob_n_reg != 3'd0;
    assign m_event_res       = ob_reg[ob_rd_reg].ev;
    assign m_out_tag         = ob_reg[ob_rd_reg].tag;
    assign m_out_destination = ob_reg[ob_rd_reg].dest;
    assign m_last            = ({1'b0, ob_rd_reg} + 3'd1 == ob_n_reg);

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) <= 32'(lpl_pkg::QUEUE_DEPTH))
        else $error("queue count overflow");
    a_rd_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, ob_rd_reg} < ob_n_reg))
        else $error("read pointer past result count");
    a_no_proc_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !proc)
        else $error("result overwritten");
    a_idle_timers: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && in_reg.func == lpl_pkg::FUNC_PWR) |=> (cnt_reg == '0 && !perm_reg))
        else $error("power loss did not clear");

endmodule

/* dv/lpl_mac_sender_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpl_mac_sender_tb
// Self-checking bench for the low-power-listening MAC sender: a queue-fed
// driver sends event items with random gaps, an in-bench model of the packet
// queue, train window and backoff timers predicts every result item, and a
// monitor, mostly under random back-pressure, compares them field by field.
// ----------------------------------------------------------------------------
module lpl_mac_sender_tb;

    typedef struct packed {
        logic [2:0]  ev;
        logic [15:0] tag;
        logic [15:0] dest;
        logic        last;
    } mac_event_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_func = '0;
    logic [15:0] s_packet_tag = '0;
    logic [15:0] s_destination = '0;
    logic [1:0]  s_channel_status = '0;
    logic [15:0] s_random_fraction = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_event_res;
    logic [15:0] m_out_tag;
    logic [15:0] m_out_destination;
    logic        m_last;

    lpl_mac_sender dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // registers of the model
    logic [31:0] r_train;
    logic [15:0] r_ib_min, r_ib_span, r_cb_min, r_cb_span, r_ack, r_bc, r_settle;
    // state of the model
    logic [2:0]  phase;
    logic        permit, lapsed;
    logic [31:0] pkt_fifo [lpl_pkg::QUEUE_DEPTH];
    int unsigned fifo_head, fifo_cnt;
    logic [32:0] win_tmr;
    logic [16:0] gap_tmr, bo_tmr;
    logic [15:0] cur_rnd;
    logic [1:0]  cur_chan;

    lpl_pkg::item_t pending_items [$];
    mac_event_t  expected_events [$];
    mac_event_t  step_events [$];
    int          errors = 0;
    int          n_results = 0;
    int          n_items = 0;
    bit          driver_done = 1'b0;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic logic [32:0] min_one(input logic [32:0] d);
        return (d == 33'd0) ? 33'd1 : d;
    endfunction

    function automatic logic [16:0] backoff_ticks(input logic [15:0] mn, input logic [15:0] sp);
        logic [31:0] prod;
        prod = 32'(cur_rnd) * 32'(sp);
        return 17'(min_one(33'(mn) + 33'(prod[31:16])));
    endfunction

    task automatic push_event(input logic [2:0] ev, input logic [15:0] tag,
                              input logic [15:0] dest);
        if (step_events.size() < 4) step_events.push_back('{ev, tag, dest, 1'b0});
    endtask

    task automatic finish_train();
        push_event(lpl_pkg::EV_FINISHED, '0, '0);
        phase = lpl_pkg::PH_IDLE;
    endtask

    task automatic drop_head();
        if (fifo_cnt != 0) begin
            fifo_head = (fifo_head + 1) % lpl_pkg::QUEUE_DEPTH;
            fifo_cnt--;
        end
    endtask

    task automatic advance_train();
        logic [15:0] tag, dest;
        bit busy;
        busy = 1'b1;
        while (busy) begin
            busy = 1'b0;
            if (fifo_cnt == 0 || !permit) begin
                finish_train();
                return;
            end
            tag = pkt_fifo[fifo_head][31:16];
            dest = pkt_fifo[fifo_head][15:0];
            case (phase)
                lpl_pkg::PH_START_TRAIN: begin
                    lapsed = 1'b0;
                    win_tmr = min_one(33'(r_train));
                    phase = lpl_pkg::PH_START_MSG;
                    busy = 1'b1;
                end
                lpl_pkg::PH_START_MSG: begin
                    if (!lapsed) begin
                        bo_tmr = backoff_ticks(r_ib_min, r_ib_span);
                        phase = lpl_pkg::PH_BACKOFF_INIT;
                    end else begin
                        if (dest != lpl_pkg::BROADCAST_ADDRESS)
                            push_event(lpl_pkg::EV_FAIL, '0, dest);
                        drop_head();
                        push_event(lpl_pkg::EV_RX, '0, '0);
                        if (fifo_cnt == 0) finish_train();
                        else begin
                            push_event(lpl_pkg::EV_BUSY, '0, '0);
                            phase = lpl_pkg::PH_START_TRAIN;
                            busy = 1'b1;
                        end
                    end
                end
                lpl_pkg::PH_BACKOFF_DONE: begin
                    if (cur_chan == lpl_pkg::CH_CLEAR) begin
                        push_event(lpl_pkg::EV_TX, tag, dest);
                        gap_tmr = 17'(min_one(33'(dest == lpl_pkg::BROADCAST_ADDRESS
                                                  ? r_bc : r_ack)));
                        phase = lpl_pkg::PH_TRANSMITTING;
                    end else if (cur_chan == lpl_pkg::CH_BUSY) begin
                        bo_tmr = backoff_ticks(r_cb_min, r_cb_span);
                        phase = lpl_pkg::PH_BACKOFF_CONG;
                    end else begin
                        bo_tmr = 17'(min_one(33'(r_settle)));
                        phase = lpl_pkg::PH_WAIT_RX;
                    end
                end
                default: finish_train();
            endcase
        end
    endtask

    task automatic start_next_packet();
        push_event(lpl_pkg::EV_RX, '0, '0);
        if (fifo_cnt == 0) finish_train();
        else begin
            push_event(lpl_pkg::EV_BUSY, '0, '0);
            phase = lpl_pkg::PH_START_TRAIN;
            advance_train();
        end
    endtask

    task automatic clear_model();
        phase = lpl_pkg::PH_IDLE;
        permit = 1'b0;
        lapsed = 1'b0;
        fifo_head = 0;
        fifo_cnt = 0;
        win_tmr = '0;
        gap_tmr = '0;
        bo_tmr = '0;
    endtask

    task automatic predict_mac_events(input lpl_pkg::item_t it);
        bit gap_fire, bo_fire;
        mac_event_t e;
        step_events.delete();
        cur_rnd = it.rnd;
        cur_chan = it.chan;
        case (it.func)
            lpl_pkg::FUNC_TICK: begin
                gap_fire = 1'b0;
                bo_fire = 1'b0;
                if (win_tmr != 0) begin
                    win_tmr--;
                    if (win_tmr == 0) lapsed = 1'b1;
                end
                if (gap_tmr != 0) begin
                    gap_tmr--;
                    gap_fire = (gap_tmr == 0);
                end
                if (bo_tmr != 0) begin
                    bo_tmr--;
                    bo_fire = (bo_tmr == 0);
                end
                if (gap_fire) begin
                    phase = lpl_pkg::PH_START_MSG;
                    advance_train();
                end
                if (bo_fire && bo_tmr == 0) begin
                    phase = lpl_pkg::PH_BACKOFF_DONE;
                    advance_train();
                end
            end
            lpl_pkg::FUNC_ENQ: begin
                if (fifo_cnt >= lpl_pkg::QUEUE_DEPTH)
                    push_event(lpl_pkg::EV_DROP, it.tag, it.dest);
                else begin
                    pkt_fifo[(fifo_head + fifo_cnt) % lpl_pkg::QUEUE_DEPTH] = {it.tag, it.dest};
                    fifo_cnt++;
                end
                if (permit && phase == lpl_pkg::PH_IDLE) start_next_packet();
            end
            lpl_pkg::FUNC_ACK: begin
                if (phase == lpl_pkg::PH_TRANSMITTING) begin
                    win_tmr = '0;
                    gap_tmr = '0;
                    drop_head();
                    phase = lpl_pkg::PH_START_TRAIN;
                    start_next_packet();
                end
            end
            lpl_pkg::FUNC_OK: begin
                permit = 1'b1;
                start_next_packet();
            end
            lpl_pkg::FUNC_STOP: begin
                permit = 1'b0;
                if (phase != lpl_pkg::PH_TRANSMITTING) begin
                    win_tmr = '0;
                    gap_tmr = '0;
                    bo_tmr = '0;
                    phase = lpl_pkg::PH_IDLE;
                end
            end
            lpl_pkg::FUNC_PWR: clear_model();
            default: ;
        endcase
        foreach (step_events[i]) begin
            e = step_events[i];
            e.last = (i == step_events.size() - 1);
            expected_events.push_back(e);
        end
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // driver
    int drv_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_mac_events('{s_func, s_packet_tag, s_destination,
                                     s_channel_status, s_random_fraction});
                n_items++;
            end
            if (!s_valid || s_ready) begin
                if (drv_gap > 0) begin
                    drv_gap <= drv_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    lpl_pkg::item_t it;
                    it = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_func <= it.func;
                    s_packet_tag <= it.tag;
                    s_destination <= it.dest;
                    s_channel_status <= it.chan;
                    s_random_fraction <= it.rnd;
                    drv_gap <= gap_len();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int mon_gap = 0;
    bit stall_free = 1'b0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                mac_event_t want;
                n_results++;
                if (expected_events.size() == 0)
                    report($sformatf("unexpected result ev=%0d", m_event_res));
                else begin
                    want = expected_events.pop_front();
                    if (m_event_res !== want.ev)
                        report($sformatf("event %0d, expected %0d", m_event_res, want.ev));
                    if (m_out_tag !== want.tag)
                        report($sformatf("tag %h, expected %h", m_out_tag, want.tag));
                    if (m_out_destination !== want.dest)
                        report($sformatf("dest %h, expected %h", m_out_destination, want.dest));
                    if (m_last !== want.last)
                        report($sformatf("last %b, expected %b", m_last, want.last));
                end
            end
            if (stall_free || mon_gap == 0) begin
                m_ready <= 1'b1;
                if (!stall_free && $urandom_range(0, 3) == 0) mon_gap <= gap_len();
            end else begin
                m_ready <= 1'b0;
                mon_gap <= mon_gap - 1;
            end
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_valid || expected_events.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            lpl_pkg::CFG_TRAIN:    r_train = val;
            lpl_pkg::CFG_IB_MIN:   r_ib_min = val[15:0];
            lpl_pkg::CFG_IB_SPAN:  r_ib_span = val[15:0];
            lpl_pkg::CFG_CB_MIN:   r_cb_min = val[15:0];
            lpl_pkg::CFG_CB_SPAN:  r_cb_span = val[15:0];
            lpl_pkg::CFG_ACK_WAIT: r_ack = val[15:0];
            lpl_pkg::CFG_BC_GAP:   r_bc = val[15:0];
            lpl_pkg::CFG_SETTLE:   r_settle = val[15:0];
            default: ;
        endcase
    endtask

    task automatic add_item(input logic [2:0] f, input logic [15:0] tag,
                            input logic [15:0] dest, input logic [1:0] ch,
                            input logic [15:0] rnd);
        pending_items.push_back('{f, tag, dest, ch, rnd});
    endtask

    function automatic logic [15:0] rand_dest();
        return ($urandom_range(0, 3) == 0) ? lpl_pkg::BROADCAST_ADDRESS : 16'($urandom);
    endfunction

    function automatic logic [1:0] rand_chan();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return lpl_pkg::CH_CLEAR;
        if (r < 8) return lpl_pkg::CH_BUSY;
        return 2'($urandom_range(2, 3));
    endfunction

    // one packet train: enqueue, permit, ticks with acks and stops, power loss
    task automatic add_session(input int ticks);
        int npk;
        npk = $urandom_range(1, 3);
        for (int i = 0; i < npk; i++)
            add_item(lpl_pkg::FUNC_ENQ, 16'($urandom), rand_dest(), 2'($urandom),
                     16'($urandom));
        add_item(lpl_pkg::FUNC_OK, 16'($urandom), 16'($urandom), 2'($urandom), 16'($urandom));
        for (int i = 0; i < ticks; i++) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 8)
                add_item(lpl_pkg::FUNC_ACK, 16'($urandom), 16'($urandom), rand_chan(),
                         16'($urandom));
            else if (r < 11)
                add_item(lpl_pkg::FUNC_ENQ, 16'($urandom), rand_dest(), rand_chan(),
                         16'($urandom));
            else if (r < 12)
                add_item(lpl_pkg::FUNC_STOP, '0, '0, rand_chan(), 16'($urandom));
            else if (r < 13)
                add_item(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom),
                         2'($urandom), 16'($urandom));
            else
                add_item(lpl_pkg::FUNC_TICK, 16'($urandom), 16'($urandom), rand_chan(),
                         16'($urandom));
        end
        add_item(lpl_pkg::FUNC_PWR, 16'($urandom), 16'($urandom), 2'($urandom), 16'($urandom));
    endtask

    task automatic set_regs(input logic [31:0] tr, input logic [15:0] ibm, input logic [15:0] ibs,
                            input logic [15:0] cbm, input logic [15:0] cbs, input logic [15:0] ack,
                            input logic [15:0] bc, input logic [15:0] st);
        write_reg(lpl_pkg::CFG_TRAIN, tr);
        write_reg(lpl_pkg::CFG_IB_MIN, 32'(ibm));
        write_reg(lpl_pkg::CFG_IB_SPAN, 32'(ibs));
        write_reg(lpl_pkg::CFG_CB_MIN, 32'(cbm));
        write_reg(lpl_pkg::CFG_CB_SPAN, 32'(cbs));
        write_reg(lpl_pkg::CFG_ACK_WAIT, 32'(ack));
        write_reg(lpl_pkg::CFG_BC_GAP, 32'(bc));
        write_reg(lpl_pkg::CFG_SETTLE, 32'(st));
    endtask

    initial begin
        r_train = 32'd10000;
        r_ib_min = 16'd10;
        r_ib_span = 16'd20;
        r_cb_min = 16'd10;
        r_cb_span = 16'd20;
        r_ack = 16'd5;
        r_bc = 16'd2;
        r_settle = 16'd2;
        clear_model();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: zero delays and short train
        set_regs(32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        add_item(lpl_pkg::FUNC_TICK, 16'hFFFF, 16'hFFFF, 2'd3, 16'hFFFF);
        add_item(lpl_pkg::FUNC_ACK, '0, '0, lpl_pkg::CH_CLEAR, '0);
        add_item(lpl_pkg::FUNC_OK, '0, '0, lpl_pkg::CH_CLEAR, '0);
        add_item(lpl_pkg::FUNC_ENQ, 16'hFFFF, 16'h0000, lpl_pkg::CH_CLEAR, '0);
        add_item(lpl_pkg::FUNC_TICK, '0, '0, 2'd2, 16'hFFFF);
        add_item(lpl_pkg::FUNC_TICK, '0, '0, lpl_pkg::CH_BUSY, 16'hFFFF);
        add_item(lpl_pkg::FUNC_TICK, '0, '0, lpl_pkg::CH_CLEAR, '0);
        add_item(lpl_pkg::FUNC_TICK, '0, '0, 2'd3, '0);
        add_item(lpl_pkg::FUNC_TICK, '0, '0, lpl_pkg::CH_CLEAR, '0);
        add_item(lpl_pkg::FUNC_ENQ, 16'h0000, lpl_pkg::BROADCAST_ADDRESS,
                 lpl_pkg::CH_CLEAR, '0);
        add_item(lpl_pkg::FUNC_TICK, '0, '0, lpl_pkg::CH_CLEAR, '0);
        add_item(lpl_pkg::FUNC_ACK, '0, '0, lpl_pkg::CH_CLEAR, '0);
        add_item(lpl_pkg::FUNC_TICK, '0, '0, lpl_pkg::CH_CLEAR, '0);
        add_item(lpl_pkg::FUNC_TICK, '0, '0, lpl_pkg::CH_CLEAR, '0);
        add_item(lpl_pkg::FUNC_STOP, '0, '0, lpl_pkg::CH_CLEAR, '0);
        add_item(3'd6, 16'h1234, 16'h5678, lpl_pkg::CH_CLEAR, '0);
        add_item(3'd7, '0, '0, lpl_pkg::CH_CLEAR, '0);
        for (int i = 0; i < lpl_pkg::QUEUE_DEPTH + 2; i++)
            add_item(lpl_pkg::FUNC_ENQ, 16'(i), 16'(i * 3), lpl_pkg::CH_CLEAR, '0);
        add_item(lpl_pkg::FUNC_OK, '0, '0, lpl_pkg::CH_CLEAR, '0);
        add_item(lpl_pkg::FUNC_PWR, '0, '0, lpl_pkg::CH_CLEAR, '0);
        wait_drained();

        // random sessions over several settings, then a directed one last
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_regs(32'd10000, 16'd10, 16'd20, 16'd10, 16'd20, 16'd5, 16'd2, 16'd2);
                1: set_regs(32'd30, 16'd1, 16'd3, 16'd0, 16'd4, 16'd3, 16'd1, 16'd1);
                2: set_regs(32'hFFFF_FFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd2, 16'd2, 16'd1);
                3: set_regs(32'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1);
                4: set_regs(32'd12, 16'd2, 16'd2, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                default: set_regs(32'd8, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd1, 16'd1, 16'd2);
            endcase
            if (ph == 5) begin
                add_item(lpl_pkg::FUNC_ENQ, 16'hA5A5, 16'h5A5A, lpl_pkg::CH_CLEAR, '0);
                add_item(lpl_pkg::FUNC_OK, '0, '0, lpl_pkg::CH_CLEAR, '0);
                add_item(lpl_pkg::FUNC_TICK, '0, '0, lpl_pkg::CH_CLEAR, '0);
                add_item(lpl_pkg::FUNC_PWR, '0, '0, lpl_pkg::CH_CLEAR, '0);
            end else begin
                for (int s = 0; s < 4; s++) add_session($urandom_range(10, 24));
            end
            stall_free = (ph == 1);
            wait_drained();
        end

        $display("summary: %0d items driven, %0d result items checked", n_items, n_results);
        $display("covered enqueue/drop, trains with acks, backoffs, settle, stop and power loss");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout");
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

/* lpl_mac_sender.f */
design/lpl_pkg.sv
design/lpl_mac_sender.sv
dv/lpl_mac_sender_tb.sv
